/* rtl/cit_pkg.sv */
// Shared types and constants for the canopy interception throughfall pipeline.
// Holds the stage map, the pipeline item record and the fixed-point constants.
`default_nettype none

package cit_pkg;

    typedef enum logic [1:0] {
        REG_CAPACITY = 2'd0,
        REG_CAP_FLOOR = 2'd1,
        REG_TIME_STEP = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_idx;

    localparam logic [31:0] CAPACITY_RST = 32'd131072;
    localparam logic [15:0] CAP_FLOOR_RST = 16'd1;
    localparam logic [31:0] TIME_STEP_RST = 32'd65536;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] E_NEG_ONE = 31'd395007543;

    localparam int SERIES_TERMS = 20;
    localparam int POW_STEPS = 31;

    localparam int ST_DIV1 = 1;
    localparam int ST_SER = ST_DIV1 + 21;
    localparam int ST_CLAMP = ST_SER + 3 * SERIES_TERMS;
    localparam int ST_POW = ST_CLAMP + 1;
    localparam int ST_OM = ST_POW + POW_STEPS;
    localparam int ST_DELTA = ST_OM + 1;
    localparam int ST_TF = ST_DELTA + 1;
    localparam int ST_SAT2 = ST_TF + 1;
    localparam int ST_DIV2 = ST_SAT2 + 1;
    localparam int N_STAGES = ST_DIV2 + 32;

    // Reciprocals floor(2^32 / t) for the series divisors; entry 1 is not used.
    localparam logic [31:0] RECIP [1:SERIES_TERMS] = '{
        32'd0, 32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882, 32'd613566756, 32'd536870912, 32'd477218588, 32'd429496729,
        32'd390451572, 32'd357913941, 32'd330382099, 32'd306783378, 32'd286331153,
        32'd268435456, 32'd252645135, 32'd238609294, 32'd226050910, 32'd214748364
    };

    typedef struct packed {
        logic [31:0] content;
        logic [31:0] prior;
        logic [31:0] rain;
        logic pos;
        logic use_exp;
        logic sat1;
        logic sat2;
        logic [32:0] rem;
        logic [20:0] q1;
        logic [30:0] term;
        logic [30:0] p;
        logic [62:0] prod;
        logic signed [32:0] sum;
        logic [30:0] r;
        logic [16:0] om;
        logic [32:0] delta;
        logic [31:0] tf;
        logic [31:0] q2;
    } t_item;

endpackage

`default_nettype wire

/* rtl/cit_in_if.sv */
// Input channel of the throughfall pipeline: valid, ready and one input beat.
// Depends on nothing else.
`default_nettype none

interface cit_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] store_content;
    logic signed [31:0] rain_in;

    modport source (output valid, output store_content, output rain_in, input ready);
    modport sink (input valid, input store_content, input rain_in, output ready);
endinterface

`default_nettype wire

/* rtl/cit_out_if.sv */
// Output channel of the throughfall pipeline: valid, ready and one result beat.
// Depends on nothing else.
`default_nettype none

interface cit_out_if;
    logic valid;
    logic ready;
    logic [31:0] throughfall_rate;

    modport source (output valid, output throughfall_rate, input ready);
    modport sink (input valid, input throughfall_rate, output ready);
endinterface

`default_nettype wire

/* rtl/canopy_interception_throughfall.sv */
// Top level of the canopy interception throughfall pipeline.
// Depends on cit_pkg, cit_in_if and cit_out_if.
//
//   channel  direction  beat
//   i_in     in         store_content, rain_in
//   o_out    out        throughfall_rate
//   i_cfg_*  in         register write (index, data)
//
// One beat enters per cycle unless the output stalls; results leave in beat order.
// The stages include two bit-per-stage long divisions, twenty series terms
// of three stages each and thirty-one e^-1 multiply stages.
// Reset clears the stage valid bits and loads the default registers.
// A stalled output freezes every stage, so nothing is lost or repeated.
`default_nettype none

module canopy_interception_throughfall (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cit_in_if.sink     i_in,
    cit_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data
);
    import cit_pkg::*;

    logic [31:0] r_cap;
    logic [15:0] r_floor;
    logic [31:0] r_ts;
    logic [N_STAGES-1:0] r_v;
    t_item r_pipe [N_STAGES];
    logic en;
    t_item last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAPACITY_RST;
            r_floor <= CAP_FLOOR_RST;
            r_ts <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CAPACITY: r_cap <= i_cfg_data;
                REG_CAP_FLOOR: r_floor <= i_cfg_data[15:0];
                REG_TIME_STEP: r_ts <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !r_v[N_STAGES-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_STAGES-2:0], i_in.valid};
        end
    end

    // Entry stage: prior content, flags and the start of the first division.
    if (1) begin : g_entry
        t_item n_stg;
        logic signed [33:0] diff;
        always_comb begin
            n_stg = '0;
            diff = 34'(i_in.store_content) - 34'(i_in.rain_in);
            n_stg.content = i_in.store_content;
            n_stg.rain = i_in.rain_in;
            n_stg.pos = !i_in.store_content[31] && (i_in.store_content != '0);
            n_stg.prior = diff[33] ? 32'd0 : diff[31:0];
            n_stg.use_exp = !i_in.rain_in[31] && (i_in.rain_in != '0)
                && (r_cap > {16'd0, r_floor});
            n_stg.sat1 = {5'd0, i_in.rain_in} >= {r_cap, 5'd0};
            n_stg.rem = {6'd0, i_in.rain_in[31:5]};
            n_stg.term = Q30_ONE;
            n_stg.sum = 33'(Q30_ONE);
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[0] <= n_stg;
        end
    end

    // rain * 2^16 / capacity, one quotient bit per stage.
    for (genvar s = 0; s < 21; s++) begin : g_div1
        localparam int J = 20 - s;
        t_item n_stg;
        logic [32:0] t;
        logic b;
        always_comb begin
            n_stg = r_pipe[ST_DIV1+s-1];
            if (J >= 16) b = n_stg.rain[(J >= 16) ? J - 16 : 0];
            else b = 1'b0;
            t = {n_stg.rem[31:0], b};
            if (t >= {1'b0, r_cap}) begin
                n_stg.rem = t - {1'b0, r_cap};
                n_stg.q1[J] = 1'b1;
            end else begin
                n_stg.rem = t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_DIV1+s] <= n_stg;
        end
    end

    // Taylor series of e^-f, three stages per term.
    for (genvar tt = 1; tt <= SERIES_TERMS; tt++) begin : g_ser
        localparam int B = ST_SER + 3 * (tt - 1);
        t_item n_a;
        t_item n_b;
        t_item n_c;
        logic [46:0] pa;
        logic [30:0] q0;
        logic [31:0] rr;
        logic [30:0] q;
        always_comb begin
            n_a = r_pipe[B-1];
            pa = 47'(n_a.term) * 47'(n_a.q1[15:0]);
            n_a.p = pa[46:16];
        end
        always_comb begin
            n_b = r_pipe[B];
            n_b.prod = 63'(n_b.p) * 63'(RECIP[tt]);
        end
        always_comb begin
            n_c = r_pipe[B+1];
            q0 = n_c.prod[62:32];
            rr = 32'(n_c.p) - 32'(q0) * 32'(tt);
            if (tt == 1) q = n_c.p;
            else if (rr >= 32'(tt)) q = q0 + 31'd1;
            else q = q0;
            n_c.term = q;
            if (tt % 2 == 1) n_c.sum = n_c.sum - 33'(q);
            else n_c.sum = n_c.sum + 33'(q);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pipe[B] <= n_a;
                r_pipe[B+1] <= n_b;
                r_pipe[B+2] <= n_c;
            end
        end
    end

    if (1) begin : g_clamp
        t_item n_stg;
        always_comb begin
            n_stg = r_pipe[ST_CLAMP-1];
            if (n_stg.sum < 0) n_stg.r = '0;
            else if (n_stg.sum > 33'(Q30_ONE)) n_stg.r = Q30_ONE;
            else n_stg.r = n_stg.sum[30:0];
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_CLAMP] <= n_stg;
        end
    end

    // Integer part of the exponent: multiply by e^-1 once per whole unit.
    for (genvar s = 0; s < POW_STEPS; s++) begin : g_pow
        t_item n_stg;
        logic [61:0] m;
        always_comb begin
            n_stg = r_pipe[ST_POW+s-1];
            m = 62'(n_stg.r) * 62'(E_NEG_ONE);
            if (5'(s) < n_stg.q1[20:16]) n_stg.r = m[60:30];
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_POW+s] <= n_stg;
        end
    end

    if (1) begin : g_om
        t_item n_stg;
        logic [16:0] e16;
        always_comb begin
            n_stg = r_pipe[ST_OM-1];
            e16 = n_stg.sat1 ? 17'd0 : n_stg.r[30:14];
            n_stg.om = 17'd65536 - e16;
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_OM] <= n_stg;
        end
    end

    if (1) begin : g_delta
        t_item n_stg;
        logic [48:0] m;
        always_comb begin
            n_stg = r_pipe[ST_DELTA-1];
            m = 49'(r_cap - n_stg.prior) * 49'(n_stg.om);
            n_stg.delta = (n_stg.prior < r_cap) ? m[48:16] : 33'd0;
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_DELTA] <= n_stg;
        end
    end

    if (1) begin : g_tf
        t_item n_stg;
        logic [33:0] grown;
        logic [31:0] kept;
        always_comb begin
            n_stg = r_pipe[ST_TF-1];
            grown = {2'd0, n_stg.prior} + {1'b0, n_stg.delta};
            if (n_stg.use_exp) kept = (grown > {2'd0, r_cap}) ? r_cap : grown[31:0];
            else kept = (n_stg.prior < r_cap) ? n_stg.prior : r_cap;
            if (n_stg.pos && (n_stg.content > kept)) n_stg.tf = n_stg.content - kept;
            else n_stg.tf = '0;
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_TF] <= n_stg;
        end
    end

    if (1) begin : g_sat2
        t_item n_stg;
        always_comb begin
            n_stg = r_pipe[ST_SAT2-1];
            n_stg.sat2 = {16'd0, n_stg.tf} >= {r_ts, 16'd0};
            n_stg.rem = {17'd0, n_stg.tf[31:16]};
            n_stg.q2 = '0;
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_SAT2] <= n_stg;
        end
    end

    // throughfall * 2^16 / time_step, one quotient bit per stage.
    for (genvar s = 0; s < 32; s++) begin : g_div2
        localparam int J = 31 - s;
        t_item n_stg;
        logic [32:0] t;
        logic b;
        always_comb begin
            n_stg = r_pipe[ST_DIV2+s-1];
            if (J >= 16) b = n_stg.tf[(J >= 16) ? J - 16 : 0];
            else b = 1'b0;
            t = {n_stg.rem[31:0], b};
            if (t >= {1'b0, r_ts}) begin
                n_stg.rem = t - {1'b0, r_ts};
                n_stg.q2[J] = 1'b1;
            end else begin
                n_stg.rem = t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_pipe[ST_DIV2+s] <= n_stg;
        end
    end

    assign last = r_pipe[N_STAGES-1];
    assign o_out.valid = r_v[N_STAGES-1];
    assign o_out.throughfall_rate = last.sat2 ? {32{last.tf != '0}} : last.q2;

endmodule

`default_nettype wire

/* bench/canopy_interception_throughfall_test.sv */
// Testbench for the canopy interception throughfall pipeline: directed and random
// beats checked against a behavioral predictor. Depends on cit_pkg, cit_in_if,
// cit_out_if and canopy_interception_throughfall.
`default_nettype none

module canopy_interception_throughfall_test;
    import cit_pkg::*;

    localparam int FRAC = 16;
    localparam longint Q1 = 64'd1 << 30;
    localparam int LATENCY = 150;
    localparam longint CYCLE_LIMIT = 1200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data = 32'd0;

    cit_in_if in_ch();
    cit_out_if out_ch();

    canopy_interception_throughfall i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [31:0] capacity_q, time_step_q;
    logic [15:0] floor_q;
    logic [31:0] rate_queue [$];
    int errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.store_content = '0;
        in_ch.rain_in = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint exp_series(longint f);
        longint total;
        longint term;
        total = Q1;
        term = Q1;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * f) >>> 30) / k;
            if (k % 2 == 1) total -= term;
            else total += term;
        end
        if (total < 0) total = 0;
        if (total > Q1) total = Q1;
        return total;
    endfunction

    function automatic longint exp_neg(longint x);
        longint whole, r, e1;
        whole = x >>> FRAC;
        if (whole >= 32) return 0;
        r = exp_series((x & ((64'd1 << FRAC) - 1)) << (30 - FRAC));
        e1 = exp_series(Q1);
        for (longint i = 0; i < whole; i++) r = (r * e1) >>> 30;
        return r >>> (30 - FRAC);
    endfunction

    function automatic logic [31:0] predict_rate(logic signed [31:0] content_in,
                                                 logic signed [31:0] rain_val);
        longint content, rain, prior, retained, tf, cap, x, om, delta;
        logic [63:0] rate;
        content = content_in;
        rain = rain_val;
        cap = capacity_q;
        if (content <= 0) return 32'd0;
        prior = content - rain;
        if (prior < 0) prior = 0;
        if (rain > 0 && capacity_q > floor_q) begin
            x = (rain << FRAC) / cap;
            om = (64'd1 << FRAC) - exp_neg(x);
            delta = 0;
            if (prior < cap) delta = ((cap - prior) * om) >>> FRAC;
            retained = prior + delta;
            if (retained > cap) retained = cap;
        end else begin
            retained = prior < cap ? prior : cap;
        end
        tf = content - retained;
        if (tf < 0) tf = 0;
        if (time_step_q == 0) return tf > 0 ? 32'hFFFFFFFF : 32'd0;
        rate = (64'(tf) << FRAC) / time_step_q;
        if (rate > 64'hFFFFFFFF) rate = 64'hFFFFFFFF;
        return rate[31:0];
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[canopy_interception_throughfall] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls per beat, plus a long hold-off on request.
    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (wait_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rate_queue.size() == 0) begin
                $error("unexpected beat: throughfall_rate %0h", out_ch.throughfall_rate);
                errors++;
            end else begin
                if (out_ch.throughfall_rate !== rate_queue[0]) begin
                    $error("throughfall_rate: expected %0h, actual %0h",
                           rate_queue[0], out_ch.throughfall_rate);
                    errors++;
                end
                void'(rate_queue.pop_front());
                n_checked++;
            end
        end
    end

    task automatic send_beat(logic signed [31:0] content, logic signed [31:0] rain,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.store_content <= content;
        in_ch.rain_in <= rain;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        rate_queue.push_back(predict_rate(content, rain));
        n_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (rate_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CAPACITY: capacity_q = data;
            REG_CAP_FLOOR: floor_q = data[15:0];
            REG_TIME_STEP: time_step_q = data;
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_beat(32'sd0, 32'sd0);
        send_beat(32'sh80000000, 32'sd65536);
        send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_beat(32'sh7FFFFFFF, 32'sh80000000);
        send_beat(32'sh7FFFFFFF, -32'sd1);
        send_beat(32'sd1, 32'sd1);
        send_beat(32'sd65536, 32'sd65536);
        send_beat(32'sd262144, 32'sd65536);
        send_beat(32'sd196608, 32'sd0);
        send_beat(32'sd100000, 32'sd4194304);
        send_beat(32'sh7FFFFFFF, 32'sd131072 * 40);
        send_beat(32'sd131072, 32'sd131072);
        send_beat(32'sh40000000, 32'sd1000);
        drain();
        write_reg(REG_TIME_STEP, 32'd1);
        send_beat(32'sh7FFFFFFF, 32'sd65536);
        send_beat(32'sd131073, 32'sd0);
        drain();
        write_reg(REG_TIME_STEP, 32'd0);
        send_beat(32'sd500000, 32'sd70000);
        send_beat(32'sd1000, 32'sd1000);
        drain();
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        write_reg(REG_CAP_FLOOR, 32'hFFFF);
        write_reg(REG_TIME_STEP, 32'hFFFFFFFF);
        send_beat(32'sd300000, 32'sd20000);
        send_beat(32'sh7FFFFFFF, 32'sd1);
        drain();
    endtask

    task automatic random_beats(int count, int content_max);
        logic signed [31:0] c, r;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: begin c = $urandom; r = $urandom; end
                1: begin c = -$urandom_range(0, 1000); r = $urandom_range(0, 1000); end
                default: begin
                    c = $urandom_range(1, content_max);
                    r = ($urandom_range(0, 5) == 0) ? -$urandom_range(0, 5000)
                        : $urandom_range(0, c);
                end
            endcase
            send_beat(c, r);
        end
    endtask

    task automatic test_random_settings();
        logic [31:0] caps [6] = '{32'd131072, 32'd0, 32'd1, 32'd65536,
                                  32'hFFFFFFFF, 32'd1000};
        for (int s = 0; s < 6; s++) begin
            write_reg(REG_CAPACITY, caps[s]);
            write_reg(REG_CAP_FLOOR, s == 5 ? 32'd0 : $urandom_range(0, 16));
            write_reg(REG_TIME_STEP, s == 4 ? 32'd65536 : $urandom_range(1, 327680));
            random_beats(240, s == 4 ? 32'h7FFFFFFF : 1000000);
            drain();
        end
    endtask

    task automatic test_back_pressure();
        write_reg(REG_CAPACITY, 32'd200000);
        write_reg(REG_CAP_FLOOR, 32'd1);
        write_reg(REG_TIME_STEP, 32'd65536);
        hold_off = 1'b1;
        for (int n = 0; n < 300; n++)
            send_beat($urandom_range(1, 600000), $urandom_range(0, 300000), 1);
        drain();
    endtask

    initial begin
        capacity_q = CAPACITY_RST;
        floor_q = CAP_FLOOR_RST;
        time_step_q = TIME_STEP_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_back_pressure();
        $display("Sent %0d beats over several capacity, floor and time step settings;",
                 n_sent);
        $display("checked %0d results, including a long output stall.", n_checked);
        if (errors == 0 && rate_queue.size() == 0) begin
            $display("[canopy_interception_throughfall] OK");
        end else begin
            $display("[canopy_interception_throughfall] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
